FILE: design/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared widths, payload types and controller/datapath interface types for
// the Miller-Rabin prime test unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mrpt_pkg;

  // operand width used from the candidate and witness fields
  localparam int NUM_WIDTH = 32;
  // counter width able to hold NUM_WIDTH itself
  localparam int CNT_W = $clog2(NUM_WIDTH + 1);
  // round counter and rounds register width
  localparam int ROUND_W = 6;

  localparam logic [ROUND_W-1:0] ROUNDS_RESET = ROUND_W'(5);
  localparam logic [NUM_WIDTH-1:0] NUM_TWO = NUM_WIDTH'(2);
  localparam logic [NUM_WIDTH-1:0] NUM_ONE = NUM_WIDTH'(1);

  // input transaction
  typedef struct packed {
    logic [31:0] candidate;
    logic [31:0] witness;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic               probable_prime;
    logic [ROUND_W-1:0] rounds_passed;
  } out_item_t;

  // modular product operation kinds
  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_SQUARE,
    OP_MULB
  } mm_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic   load;
    logic   mm_start;
    mm_op_t mm_op;
    logic   strip;
    logic   shl;
    logic   exp_init;
    logic   s_inc;
    logic   finish;
    logic   pass;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic trivial_fail;
    logic mm_done;
    logic d_even;
    logic e_top;
    logic ebits_zero;
    logic x_is_one;
    logic x_is_nm1;
    logic s_done;
    logic s_zero;
    logic reach;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt_mulmod
// Bit-serial modular multiplier: (addend * mult) mod modulus, one multiplier
// bit per cycle, MSB first, double-and-add with conditional subtracts.
// Requires addend < modulus and modulus >= 2.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_mulmod (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [mrpt_pkg::NUM_WIDTH-1:0] addend,
  input  wire logic [mrpt_pkg::NUM_WIDTH-1:0] mult,
  input  wire logic [mrpt_pkg::NUM_WIDTH-1:0] modulus,
  output logic                                done,
  output logic      [mrpt_pkg::NUM_WIDTH-1:0] result
);
  import mrpt_pkg::*;

  logic [NUM_WIDTH-1:0] acc_r;
  logic [NUM_WIDTH-1:0] add_r;
  logic [NUM_WIDTH-1:0] mult_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [NUM_WIDTH:0] mod_ext;
  logic [NUM_WIDTH:0] dbl;
  logic [NUM_WIDTH:0] dbl_red;
  logic [NUM_WIDTH:0] sum;
  logic [NUM_WIDTH:0] sum_red;

  // double, reduce, add, reduce
  assign mod_ext = {1'b0, modulus};
  assign dbl     = {acc_r, 1'b0};
  assign dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
  assign sum     = {1'b0, dbl_red[NUM_WIDTH-1:0]}
                 + (mult_r[NUM_WIDTH-1] ? {1'b0, add_r} : '0);
  assign sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= '0;
      add_r  <= addend;
      mult_r <= mult;
    end else if (busy_r) begin
      acc_r  <= sum_red[NUM_WIDTH-1:0];
      mult_r <= {mult_r[NUM_WIDTH-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

FILE: design/mrpt_dpath.sv
// ----------------------------------------------------------------------------
// mrpt_dpath
// Datapath: candidate and witness registers, exponent shifter, counters,
// shared modular multiplier, round counting and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mrpt_pkg::in_item_t           in_data,
  input  wire logic                         cfg_wr_en,
  input  wire logic [mrpt_pkg::ROUND_W-1:0] cfg_wr_data,
  input  wire mrpt_pkg::dp_cmd_t            cmd,
  output mrpt_pkg::dp_status_t              status,
  output mrpt_pkg::out_item_t               out_data
);
  import mrpt_pkg::*;

  logic [NUM_WIDTH-1:0] n_r;
  logic [NUM_WIDTH-1:0] nm1_r;
  logic [NUM_WIDTH-1:0] wit_r;
  logic [NUM_WIDTH-1:0] b_r;
  logic [NUM_WIDTH-1:0] x_r;
  logic [NUM_WIDTH-1:0] e_r;
  logic [CNT_W-1:0]     ebits_r;
  logic [CNT_W-1:0]     r_r;
  logic [CNT_W-1:0]     s_r;
  mm_op_t               op_r;
  logic [ROUND_W-1:0]   rounds_r;
  logic [ROUND_W-1:0]   round_cnt_r;
  out_item_t            out_data_r;

  logic [NUM_WIDTH-1:0] cand;
  logic [NUM_WIDTH-1:0] mm_addend;
  logic [NUM_WIDTH-1:0] mm_mult;
  logic [NUM_WIDTH-1:0] mm_result;
  logic                 mm_done;
  logic [ROUND_W-1:0]   cnt_inc;
  logic [ROUND_W-1:0]   need;
  logic                 reach;

  assign cand = in_data.candidate[NUM_WIDTH-1:0];

  // operand selection for the shared multiplier
  always_comb begin
    case (cmd.mm_op)
      OP_REDUCE: begin
        mm_addend = NUM_ONE;
        mm_mult   = wit_r;
      end
      OP_SQUARE: begin
        mm_addend = x_r;
        mm_mult   = x_r;
      end
      OP_MULB: begin
        mm_addend = b_r;
        mm_mult   = x_r;
      end
      default: begin
        mm_addend = x_r;
        mm_mult   = x_r;
      end
    endcase
  end

  mrpt_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mm_start),
    .addend  (mm_addend),
    .mult    (mm_mult),
    .modulus (n_r),
    .done    (mm_done),
    .result  (mm_result)
  );

  // round counting
  assign cnt_inc = round_cnt_r + 1'b1;
  assign need    = (rounds_r == '0) ? ROUND_W'(1) : rounds_r;
  assign reach   = (cnt_inc >= need);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rounds_r    <= ROUNDS_RESET;
      round_cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        rounds_r <= cfg_wr_data;
      end
      if (cmd.finish) begin
        if (!cmd.pass || reach) begin
          round_cnt_r <= '0;
        end else begin
          round_cnt_r <= cnt_inc;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r     <= cand;
      nm1_r   <= cand - 1'b1;
      e_r     <= cand - 1'b1;
      wit_r   <= in_data.witness[NUM_WIDTH-1:0];
      ebits_r <= CNT_W'(NUM_WIDTH - 1);
      r_r     <= '0;
      s_r     <= '0;
    end
    if (cmd.strip) begin
      e_r <= {1'b0, e_r[NUM_WIDTH-1:1]};
      r_r <= r_r + 1'b1;
    end
    if (cmd.shl) begin
      e_r     <= {e_r[NUM_WIDTH-2:0], 1'b0};
      ebits_r <= ebits_r - 1'b1;
    end
    if (cmd.exp_init) begin
      x_r <= b_r;
      e_r <= {e_r[NUM_WIDTH-2:0], 1'b0};
    end
    if (cmd.s_inc) begin
      s_r <= s_r + 1'b1;
    end
    if (cmd.mm_start) begin
      op_r <= cmd.mm_op;
    end
    if (mm_done) begin
      if (op_r == OP_REDUCE) begin
        b_r <= mm_result;
      end else begin
        x_r <= mm_result;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (!cmd.pass) begin
        out_data_r.probable_prime <= 1'b0;
        out_data_r.rounds_passed  <= round_cnt_r;
      end else if (reach) begin
        out_data_r.probable_prime <= 1'b1;
        out_data_r.rounds_passed  <= cnt_inc;
      end
    end
  end

  assign out_data = out_data_r;

  // status back to the controller
  assign status.trivial_fail = (n_r < NUM_TWO) || ((n_r != NUM_TWO) && !n_r[0]);
  assign status.mm_done      = mm_done;
  assign status.d_even       = !e_r[0];
  assign status.e_top        = e_r[NUM_WIDTH-1];
  assign status.ebits_zero   = (ebits_r == '0);
  assign status.x_is_one     = (x_r == NUM_ONE);
  assign status.x_is_nm1     = (x_r == nm1_r);
  assign status.s_done       = (s_r == r_r);
  assign status.s_zero       = (s_r == '0);
  assign status.reach        = reach;

endmodule

`default_nettype wire

FILE: design/mrpt_ctrl.sv
// ----------------------------------------------------------------------------
// mrpt_ctrl
// Controller: sequences one round (screen, reduce witness, strip twos,
// left-to-right exponentiation, squaring loop) and hands the verdict to the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire mrpt_pkg::dp_status_t status,
  output mrpt_pkg::dp_cmd_t         cmd
);
  import mrpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_REDUCE,
    S_STRIP,
    S_NORM,
    S_EXP_INIT,
    S_EXP_BIT,
    S_EXP_SQ,
    S_EXP_DEC,
    S_EXP_MUL,
    S_SQ_CHECK,
    S_SQ_WAIT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   verdict;

  assign verdict  = !pass_r || status.reach;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    cmd           = '0;
    cmd.pass      = pass_r;
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.trivial_fail) begin
          pass_nxt  = 1'b0;
          state_nxt = S_FINISH;
        end else begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = OP_REDUCE;
          state_nxt    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (status.mm_done) state_nxt = S_STRIP;
      end
      S_STRIP: begin
        if (status.d_even) begin
          cmd.strip = 1'b1;
        end else begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (!status.e_top) begin
          cmd.shl = 1'b1;
        end else begin
          state_nxt = S_EXP_INIT;
        end
      end
      S_EXP_INIT: begin
        cmd.exp_init = 1'b1;
        state_nxt    = S_EXP_BIT;
      end
      S_EXP_BIT: begin
        if (status.ebits_zero) begin
          state_nxt = S_SQ_CHECK;
        end else begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = OP_SQUARE;
          state_nxt    = S_EXP_SQ;
        end
      end
      S_EXP_SQ: begin
        if (status.mm_done) state_nxt = S_EXP_DEC;
      end
      S_EXP_DEC: begin
        if (status.e_top) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = OP_MULB;
          state_nxt    = S_EXP_MUL;
        end else begin
          cmd.shl   = 1'b1;
          state_nxt = S_EXP_BIT;
        end
      end
      S_EXP_MUL: begin
        if (status.mm_done) begin
          cmd.shl   = 1'b1;
          state_nxt = S_EXP_BIT;
        end
      end
      S_SQ_CHECK: begin
        if (status.s_done || status.x_is_one || status.x_is_nm1) begin
          pass_nxt  = status.x_is_nm1 || status.s_zero;
          state_nxt = S_FINISH;
        end else begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = OP_SQUARE;
          state_nxt    = S_SQ_WAIT;
        end
      end
      S_SQ_WAIT: begin
        if (status.mm_done) begin
          cmd.s_inc = 1'b1;
          state_nxt = S_SQ_CHECK;
        end
      end
      S_FINISH: begin
        // hold while a verdict has nowhere to go
        if (!(verdict && out_valid_r && out_stall)) begin
          cmd.finish = 1'b1;
          if (verdict) out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/miller_rabin_prime_test_unit.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_unit
// One Miller-Rabin witness round per input transaction, with round counting
// and a verdict transaction when a round fails or enough rounds have passed.
// ----------------------------------------------------------------------------
// Each input transaction carries a candidate n and a witness a and runs one
// round; a result transaction (probable_prime, rounds_passed) appears only
// when a round shows n composite or the passed-round count reaches the rounds
// register (reset 5, zero acts as one). Candidates below two and even ones
// other than two are rejected straight from the check state. Otherwise all
// arithmetic goes through one bit-serial modular multiplier: one product
// reduces the witness, the twos are stripped from n-1 and its odd part d is
// aligned, then one squaring per bit of d after the leading one plus one
// multiply per set bit after the leading one, then up to r squarings. One
// round is in flight at a time; the next transaction is taken while a
// verdict waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module miller_rabin_prime_test_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire mrpt_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output mrpt_pkg::out_item_t               out_data,
  input  wire logic                         cfg_wr_en,
  input  wire logic [mrpt_pkg::ROUND_W-1:0] cfg_wr_data
);
  import mrpt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mrpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mrpt_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_data    (out_data)
  );

  // one round at a time: an accepted transaction closes the input
  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a round was still running");

  // a probable-prime verdict always follows at least one passed round
  a_prime_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.probable_prime |-> out_data.rounds_passed != '0)
    else $error("probable prime reported with zero rounds passed");

endmodule

`default_nettype wire

FILE: sim/mrpt_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_verdict_checker
// Watches both channels and the rounds register port of the prime test unit,
// predicts each verdict from the accepted rounds and compares every result
// transaction field by field with the oldest predicted verdict.
// ----------------------------------------------------------------------------

module mrpt_verdict_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  mrpt_pkg::in_item_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  mrpt_pkg::out_item_t          out_data,
  input  logic                         cfg_wr_en,
  input  logic [mrpt_pkg::ROUND_W-1:0] cfg_wr_data,
  output int                           fail_count,
  output int                           pending,
  output int                           prime_verdicts,
  output int                           composite_verdicts
);
  import mrpt_pkg::*;

  // predictor state: rounds register and passed-round counter
  logic [ROUND_W-1:0] rounds_setting;
  logic [ROUND_W-1:0] passed_rounds;
  out_item_t          verdict_q[$];
  int                 mismatches = 0;
  int                 primes_seen = 0;
  int                 composites_seen = 0;

  assign fail_count         = mismatches;
  assign prime_verdicts     = primes_seen;
  assign composite_verdicts = composites_seen;

  initial pending = 0;

  // one witness round on an odd candidate (or two), full 64-bit products
  function automatic bit round_holds(logic [NUM_WIDTH-1:0] n, logic [NUM_WIDTH-1:0] a);
    logic [63:0] nm1, d, t, x, b, e;
    nm1 = n - 1;
    d = nm1;
    while (!d[0]) d = d >> 1;
    // x = (a mod n)^d mod n
    b = a % n;
    x = 64'd1 % n;
    e = d;
    while (e != 0) begin
      if (e[0]) x = (x * b) % n;
      b = (b * b) % n;
      e = e >> 1;
    end
    // square until n-1 is reached or x settles at 1 or n-1
    t = d;
    while (t != nm1 && x != 64'd1 && x != nm1) begin
      x = (x * x) % n;
      t = t << 1;
    end
    return !(x != nm1 && !t[0]);
  endfunction

  // update the round count for one transaction and queue a verdict if due
  task automatic predict_round(input in_item_t it);
    logic [NUM_WIDTH-1:0] n, a;
    logic [ROUND_W-1:0]   need;
    bit                   ok;
    out_item_t            v;
    n = it.candidate[NUM_WIDTH-1:0];
    a = it.witness[NUM_WIDTH-1:0];
    // zero in the rounds register acts as one
    need = (rounds_setting == '0) ? ROUND_W'(1) : rounds_setting;
    if (n < NUM_TWO || (n != NUM_TWO && !n[0])) ok = 1'b0;
    else ok = round_holds(n, a);
    if (!ok) begin
      v.probable_prime = 1'b0;
      v.rounds_passed  = passed_rounds;
      passed_rounds    = '0;
      verdict_q.push_back(v);
    end else begin
      passed_rounds = passed_rounds + 1'b1;
      if (passed_rounds >= need) begin
        v.probable_prime = 1'b1;
        v.rounds_passed  = passed_rounds;
        passed_rounds    = '0;
        verdict_q.push_back(v);
      end
    end
  endtask

  // compare one accepted result with the oldest predicted verdict
  task automatic check_verdict(input out_item_t got);
    out_item_t want;
    if (verdict_q.size() == 0) begin
      $error("result with no verdict pending: probable_prime %0d rounds_passed %0d",
             got.probable_prime, got.rounds_passed);
      mismatches++;
    end else begin
      want = verdict_q.pop_front();
      if (got.probable_prime !== want.probable_prime) begin
        $error("probable_prime: expected %0d, got %0d", want.probable_prime,
               got.probable_prime);
        mismatches++;
      end
      if (got.rounds_passed !== want.rounds_passed) begin
        $error("rounds_passed: expected %0d, got %0d", want.rounds_passed,
               got.rounds_passed);
        mismatches++;
      end
      if (want.probable_prime) primes_seen++;
      else composites_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rounds_setting = ROUNDS_RESET;
      passed_rounds  = '0;
    end else begin
      if (cfg_wr_en) rounds_setting = cfg_wr_data;
      if (out_valid && !out_stall) check_verdict(out_data);
      if (in_valid && !in_stall) predict_round(in_data);
    end
    pending <= verdict_q.size();
  end

endmodule

FILE: sim/tb_miller_rabin_prime_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_prime_test_unit
// Drives witness rounds into the prime test unit: a directed set of corner
// candidates, then random round sequences on primes, composites and noise
// under several rounds settings, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_miller_rabin_prime_test_unit;
  import mrpt_pkg::*;

  localparam longint TIMEOUT_NS  = 64'd48_000_000;
  localparam int     DRAIN_WAIT  = 3500;
  localparam int     LONG_HOLD   = 1500;
  localparam int     PHASE_ITEMS = 30;
  localparam logic [31:0] TOP_PRIME = 32'd4294967291;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_wr_en = 1'b0;
  logic [ROUND_W-1:0] cfg_wr_data = '0;

  int fail_count, pending, prime_verdicts, composite_verdicts;
  int items_sent = 0;
  int settings_used = 1;
  bit calm = 1'b0;
  bit squeeze = 1'b0;

  miller_rabin_prime_test_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  mrpt_verdict_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data          (out_data),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .prime_verdicts    (prime_verdicts),
    .composite_verdicts(composite_verdicts)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  // offer one transaction after a random gap and wait until it is taken
  task automatic offer(input logic [31:0] cand, input logic [31:0] wit);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{candidate: cand, witness: wit};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // stop offering and let the unit finish every round in flight
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_rounds(input logic [ROUND_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  function automatic bit is_prime(logic [31:0] v);
    longint unsigned f;
    if (v < 2) return 1'b0;
    if (!v[0]) return v == 32'd2;
    for (f = 3; f * f <= v; f += 2)
      if (v % f == 0) return 1'b0;
    return 1'b1;
  endfunction

  // random value of random bit length, mostly short to keep rounds quick
  function automatic logic [31:0] pick_size();
    int          bits;
    logic [31:0] v;
    bits = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(4, 20);
    v = $urandom();
    if (bits < 32) v = v & ((32'd1 << bits) - 1);
    return v;
  endfunction

  function automatic logic [31:0] pick_prime();
    logic [31:0] v;
    v = pick_size();
    if (v > TOP_PRIME) return TOP_PRIME;
    if (v < 3) v = 3;
    while (!is_prime(v)) v++;
    return v;
  endfunction

  // mostly in-range witnesses, some raw 32-bit ones and some multiples of n
  function automatic logic [31:0] pick_witness(logic [31:0] n);
    logic [63:0] prod;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        prod = 64'(n) * $urandom_range(0, 3);
        return (prod[63:32] == 0) ? prod[31:0] : n;
      end
      default: return $urandom_range(1, (n > 2) ? n - 1 : 1);
    endcase
  endfunction

  // one round sequence: a prime run, a random odd candidate or plain noise
  task automatic random_sequence(input int need);
    int          kind, len;
    logic [31:0] n;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      n = pick_prime();
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, need) : need;
      repeat (len) offer(n, pick_witness(n));
    end else if (kind < 8) begin
      n = pick_size() | 32'd1;
      offer(n, pick_witness(n));
    end else begin
      offer($urandom(), $urandom());
    end
  endtask

  // result side: random stall per transaction, one long hold on request
  initial begin
    int hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        hold = calm ? 0 : $urandom_range(0, 5);
        if (hold != 0) begin
          out_stall <= 1'b1;
          while (hold != 0) begin
            @(posedge clk);
            if (out_valid) hold--;
          end
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // stimulus
  initial begin
    logic [ROUND_W-1:0] plan[6];
    logic [ROUND_W-1:0] setting;
    int                 need, phase_start;
    plan[0] = ROUND_W'(1);
    plan[1] = ROUND_W'(63);
    plan[2] = ROUND_W'(0);
    plan[3] = ROUND_W'($urandom_range(2, 62));
    plan[4] = ROUND_W'(2);
    plan[5] = ROUND_W'($urandom_range(1, 63));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // trivial rejects and the all-ones odd candidate, rounds at reset value
    offer(32'd0, 32'd0);
    offer(32'd1, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFE, 32'h1234_5678);
    offer(32'd4, 32'd3);
    offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // candidate two passes for any witness
    offer(32'd2, 32'd0);
    offer(32'd2, 32'hFFFF_FFFF);
    offer(32'd2, 32'd2);
    offer(32'd2, 32'd1);
    offer(32'd2, 32'h8000_0000);
    // largest 32-bit prime, last witness a multiple of it
    offer(TOP_PRIME, 32'd2);
    offer(TOP_PRIME, 32'hFFFF_FFFF);
    offer(TOP_PRIME, TOP_PRIME - 1);
    offer(TOP_PRIME, 32'd1);
    offer(TOP_PRIME, TOP_PRIME);
    // strong pseudoprime to base two, caught by base three
    offer(32'd2047, 32'd2);
    offer(32'd2047, 32'd3);
    // candidate changes between rounds, count carries on
    offer(32'd3, 32'd2);
    offer(32'd5, 32'd3);
    offer(32'd7, 32'd6);
    offer(32'd11, 32'd10);
    offer(32'd13, 32'h7FFF_FFFF);
    // zero witness after reduction
    offer(32'd3, 32'd3);
    offer(32'd9, 32'd0);

    // burst of quick rejects while the result side holds off
    squeeze = 1'b1;
    repeat (12) offer($urandom() & 32'hFFFF_FFFE, $urandom());

    // random sequences under each rounds setting
    foreach (plan[p]) begin
      drain();
      setting = plan[p];
      write_rounds(setting);
      need = (setting == '0) ? 1 : int'(setting);
      calm = ($urandom_range(0, 3) == 0);
      phase_start = items_sent;
      if (need > 8) begin
        // one full run at the large setting on a short prime
        repeat (need) offer(32'd101, $urandom_range(1, 100));
      end
      while (items_sent - phase_start < PHASE_ITEMS) random_sequence(need);
    end
    calm = 1'b0;
    drain();

    $display("covered %0d rounds over %0d rounds settings", items_sent, settings_used);
    $display("verdicts checked: %0d probable prime, %0d composite",
             prime_verdicts, composite_verdicts);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
